FILE: rtl/bupr_pkg.sv
`default_nettype none

package bupr_pkg;

   // Field widths of the configuration register and the result word.
   localparam int CfgW  = 13;
   localparam int CodeW = 8;
   localparam int NibW  = 4;

   // Line width after reset, in pixels.
   localparam logic [CfgW-1:0] LineWidthReset = 13'd256;

   // Longest run that is coded in one piece.
   localparam logic [7:0] MaxRunChunk = 8'd255;

   // Escape nibble that opens a three-nibble run code.
   localparam logic [NibW-1:0] EscNibble = 4'h0;

   // One pixel produces at most this many code bytes.
   localparam int MaxBytes = 4;
   localparam int GroupW   = MaxBytes * CodeW;

   // Result queue between the coder and the output port.
   localparam int FifoDepth = 8;
   localparam int FifoAw    = 3;

   typedef logic [7:0] run_len_type;

   // Code bytes produced by one pixel, earliest byte in the low bits.
   typedef struct packed {
      logic [2:0]        count;
      logic [GroupW-1:0] bytes;
      logic              last;
   } group_type;

endpackage

`default_nettype wire

FILE: rtl/bupr_if.sv
`default_nettype none

interface bupr_req_if;
   logic valid;
   logic ready;
   logic ink;
   logic last_pixel;

   modport source (output valid, output ink, output last_pixel, input ready);
   modport sink (input valid, input ink, input last_pixel, output ready);
endinterface

interface bupr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bupr_pkg::CodeW-1:0] code_byte;
   logic                      last_byte;

   modport source (output valid, output code_byte, output last_byte, input ready);
   modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/bupr_line_store.sv
`default_nettype none

// One-bit line store. The read returns the old contents of the entry that is
// written in the same cycle, so one access both fetches the pixel above and
// stores the current pixel.
module bupr_line_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [AW-1:0] addr,
   input  wire logic          wdata,
   output logic               rdata
);

   logic mem_ff [DEPTH];
   logic rd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         mem_ff[addr] <= wdata;
         rd_ff        <= mem_ff[addr];
      end
   end

   assign rdata = rd_ff;

endmodule

`default_nettype wire

FILE: rtl/bupr_nibble_coder.sv
`default_nettype none

// Run-length coder: keeps the open run and a half-filled byte, and turns one
// coded bit into the code bytes that it completes.
module bupr_nibble_coder (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  wire logic          bit_in,
   input  wire logic          last,
   output bupr_pkg::group_type group
);

   logic                  run_value_ff, run_value_in;
   bupr_pkg::run_len_type run_len_ff, run_len_in;
   logic [3:0]            held_ff, held_in;
   logic                  pend_ff, pend_in;

   logic                  change, long_run, short_a, short_b;
   bupr_pkg::run_len_type new_len;
   logic [23:0]           code_a;
   logic [11:0]           code_b;
   logic [2:0]            num_a;
   logic [1:0]            num_b;
   logic [3:0]            num_all;
   logic [3:0]            num_pad;
   logic [31:0]           seq;
   logic [4:0]            shift_a, shift_b;
   logic [3:0]            top_idx;

   always_comb begin
      change   = bit_in != run_value_ff;
      long_run = !change && (run_len_ff == bupr_pkg::MaxRunChunk);

      // The closing run: one nibble when it fits, else escape, low, high.
      short_a = (run_len_ff != '0) && (run_len_ff[7:4] == '0);
      if (change) begin
         num_a  = short_a ? 3'd1 : 3'd3;
         code_a = short_a ? {20'h0, run_len_ff[3:0]}
                          : {12'h0, run_len_ff[7:4], run_len_ff[3:0], bupr_pkg::EscNibble};
      end else if (long_run) begin
         // A full chunk of 255 followed by an empty run of the other color.
         num_a  = 3'd6;
         code_a = {bupr_pkg::EscNibble, 4'h0, 4'h0, 4'hf, 4'hf, bupr_pkg::EscNibble};
      end else begin
         num_a  = 3'd0;
         code_a = '0;
      end

      new_len = (change || long_run) ? 8'd1 : run_len_ff + 8'd1;

      // The final pixel flushes the run it leaves open.
      short_b = new_len[7:4] == '0;
      if (last) begin
         num_b  = short_b ? 2'd1 : 2'd3;
         code_b = short_b ? {8'h0, new_len[3:0]}
                          : {new_len[7:4], new_len[3:0], bupr_pkg::EscNibble};
      end else begin
         num_b  = 2'd0;
         code_b = '0;
      end

      shift_a = {2'b00, pend_ff, 2'b00};
      shift_b = 5'({1'b0, pend_ff} + {1'b0, num_a}) << 2;
      seq     = {28'h0, (pend_ff ? held_ff : 4'h0)}
                | ({8'h0, code_a} << shift_a)
                | ({20'h0, code_b} << shift_b);

      num_all = 4'(pend_ff) + 4'(num_a) + 4'(num_b);
      // An odd nibble at the end of the image is padded with a zero.
      num_pad = (last && num_all[0]) ? num_all + 4'd1 : num_all;
      top_idx = num_all - 4'd1;

      group.count = num_pad[3:1];
      group.bytes = seq;
      group.last  = last;

      if (!last && num_all[0]) begin
         pend_in = 1'b1;
         held_in = seq[{top_idx[2:0], 2'b00} +: 4];
      end else begin
         pend_in = 1'b0;
         held_in = '0;
      end

      if (last) begin
         run_value_in = 1'b0;
         run_len_in   = '0;
      end else begin
         run_value_in = bit_in;
         run_len_in   = new_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff <= 1'b0;
         run_len_ff   <= '0;
         held_ff      <= '0;
         pend_ff      <= 1'b0;
      end else if (fire) begin
         run_value_ff <= run_value_in;
         run_len_ff   <= run_len_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/bilevel_up_prediction_nibble_rle.sv
// Path: an accepted pixel waits in the stage one registers, and when it fires its code
// words are written to the result queue. Throughput: one pixel per cycle while the
// eight-word queue holds four words or fewer; a pixel waits in stage one while it holds
// more. The output moves one code word per cycle while the receiver is ready.
// Reset clears the column, the first-row flag, the open run and the queue at once.
// The line store is not cleared; it is written along the first row of the image.
`default_nettype none

module bilevel_up_prediction_nibble_rle #(
   parameter int LINE_MAX = 4096
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bupr_req_if.sink                       req_ch,
   bupr_rsp_if.source                     rsp_ch,
   input  wire logic                      csr_we,
   input  wire logic [bupr_pkg::CfgW-1:0] csr_wdata
);

   // Address width of the line store, and a compare width that holds both the
   // register value and LINE_MAX itself.
   localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam int WW = $clog2(LINE_MAX + 1);
   localparam int CW = (WW > bupr_pkg::CfgW) ? WW : bupr_pkg::CfgW;

   // ---------------------------------------------------------------------
   // Configuration. A width of zero acts as one pixel, and a width above
   // the line store depth is clipped to the depth.
   // ---------------------------------------------------------------------
   logic [bupr_pkg::CfgW-1:0] line_width_ff;
   logic [CW-1:0]             width_raw, width_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= bupr_pkg::LineWidthReset;
      end else if (csr_we) begin
         line_width_ff <= csr_wdata;
      end
   end

   always_comb begin
      width_raw = CW'(line_width_ff);
      if (width_raw == '0) begin
         width_eff = CW'(1);
      end else if (width_raw > CW'(LINE_MAX)) begin
         width_eff = CW'(LINE_MAX);
      end else begin
         width_eff = width_raw;
      end
   end

   // ---------------------------------------------------------------------
   // Stage one: column tracking and the line store access. The store is
   // read and written at the current column in the same cycle; the read
   // gives the pixel of the row above, the write leaves the current pixel
   // for the row below. Consecutive pixels touch different entries except
   // for a one-pixel row, where the previous write has already landed.
   // ---------------------------------------------------------------------
   logic          accept;
   logic [AW-1:0] col_ff, col_in;
   logic          first_row_ff, first_row_in;
   logic [CW-1:0] col_next;
   logic          wrap;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_ink_ff;
   logic          s1_first_ff;
   logic          s1_last_ff;
   logic          above;
   logic          fire;
   logic          coded_bit;
   logic [3:0]    fifo_cnt_ff, fifo_cnt_in;

   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      col_next     = CW'(col_ff) + CW'(1);
      wrap         = col_next >= width_eff;
      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         if (req_ch.last_pixel) begin
            // The next word starts a new image.
            col_in       = '0;
            first_row_in = 1'b1;
         end else if (wrap) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in = col_next[AW-1:0];
         end
      end
   end

   bupr_line_store #(
      .DEPTH (LINE_MAX),
      .AW    (AW)
   ) u_line_store (
      .clock (clock),
      .en    (accept),
      .addr  (col_ff),
      .wdata (req_ch.ink),
      .rdata (above)
   );

   // The stage hands its pixel on when the queue can take a full group.
   assign fire         = s1_valid_ff &&
                         (fifo_cnt_ff <= 4'(bupr_pkg::FifoDepth - bupr_pkg::MaxBytes));
   assign req_ch.ready = !s1_valid_ff || fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
      end else begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ink_ff   <= req_ch.ink;
         s1_first_ff <= first_row_ff;
         s1_last_ff  <= req_ch.last_pixel;
      end
   end

   // ---------------------------------------------------------------------
   // Stage two: up prediction and run-length coding. The first row codes
   // the ink bit itself; every later row codes its difference from above.
   // ---------------------------------------------------------------------
   bupr_pkg::group_type group;

   assign coded_bit = s1_ink_ff ^ (!s1_first_ff && above);

   bupr_nibble_coder u_coder (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .bit_in (coded_bit),
      .last   (s1_last_ff),
      .group  (group)
   );

   // ---------------------------------------------------------------------
   // Result queue. A pixel pushes up to four words at once; the output
   // port pops one word per cycle while the receiver is ready. The last-word
   // flag goes on the final word of the group that the last pixel produces.
   // ---------------------------------------------------------------------
   logic [bupr_pkg::CodeW-1:0]  fifo_data_ff [bupr_pkg::FifoDepth];
   logic                        fifo_last_ff [bupr_pkg::FifoDepth];
   logic [bupr_pkg::FifoAw-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bupr_pkg::FifoAw-1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0]                  push_num;
   logic                        pop;

   assign push_num = fire ? group.count : 3'd0;
   assign pop      = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      wr_ptr_in   = wr_ptr_ff + bupr_pkg::FifoAw'(push_num);
      rd_ptr_in   = rd_ptr_ff + bupr_pkg::FifoAw'(pop);
      fifo_cnt_in = fifo_cnt_ff + 4'(push_num) - 4'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < bupr_pkg::MaxBytes; i++) begin
         if (3'(i) < push_num) begin
            fifo_data_ff[wr_ptr_ff + bupr_pkg::FifoAw'(i)] <=
               group.bytes[i*bupr_pkg::CodeW +: bupr_pkg::CodeW];
            fifo_last_ff[wr_ptr_ff + bupr_pkg::FifoAw'(i)] <=
               group.last && (3'(i + 1) == push_num);
         end
      end
   end

   assign rsp_ch.valid     = fifo_cnt_ff != '0;
   assign rsp_ch.code_byte = fifo_data_ff[rd_ptr_ff];
   assign rsp_ch.last_byte = fifo_last_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   // Depth of the line store in the block; the DUT keeps its default.
   localparam int LineMax = 4096;
   // Widest row of the narrow images; the directed part writes this many columns first.
   localparam int MaxNarrow = 24;
   // Repeated pixels below the first row of the long-run image.
   localparam int LongCopies = 248;
   // Runs of 1 to this value minus one fit in a single nibble.
   localparam int ShortRunLimit = 16;
   // Nibble used to fill the high half of the final code word.
   localparam logic [bupr_pkg::NibW-1:0] PadNibble = 4'h0;
   // Longest wait either side draws before it moves a word.
   localparam int MaxGap = 12;
   // Cycles to let pass after the last expected word, for a pixel still in the block.
   localparam int SettleCycles = 4;
   // Random pixels to send after the directed part.
   localparam int RandomPixels = 48;
   // The slowest correct run is a few hundred pixels and ends far below this limit.
   localparam int CycleLimit = 1_000_000;

   // How the pixels of one planned image row are chosen.
   typedef enum int {
      RowRandom,
      RowCopy,
      RowFlip,
      RowSolid,
      RowRuns
   } row_mode_type;

   // The scoreboard carries its own copy of the encoder state. Every accepted pixel is
   // coded here into the code words it must produce, and every word that leaves the block
   // is compared with the oldest of them.
   class rle_scoreboard;
      typedef struct packed {
         logic [bupr_pkg::CodeW-1:0] code_byte;
         logic                       last_byte;
      } code_word_type;

      code_word_type              expected_words[$];
      code_word_type              pixel_words[$];
      bit                         line_store[LineMax];
      logic [bupr_pkg::CfgW-1:0]  line_width;
      int unsigned                column;
      int unsigned                run_len;
      bit                         first_row;
      bit                         run_ink;
      bit                         nibble_held;
      logic [bupr_pkg::NibW-1:0]  held_nibble;
      int unsigned                pixels_noted;
      int unsigned                words_checked;
      int unsigned                errors;

      function new();
         line_width    = bupr_pkg::LineWidthReset;
         pixels_noted  = 0;
         words_checked = 0;
         errors        = 0;
         start_image();
      endfunction

      // Column, row flag, open run and held nibble reset; the line store and width stay.
      function void start_image();
         column      = 0;
         first_row   = 1'b1;
         run_ink     = 1'b0;
         run_len     = 0;
         held_nibble = '0;
         nibble_held = 1'b0;
      endfunction

      function void set_width(logic [bupr_pkg::CfgW-1:0] w);
         line_width = w;
      endfunction

      // Nibbles pair up low half first.
      function void put_nibble(logic [bupr_pkg::NibW-1:0] v);
         if (nibble_held) begin
            pixel_words.push_back('{code_byte: {v, held_nibble}, last_byte: 1'b0});
            held_nibble = '0;
            nibble_held = 1'b0;
         end else begin
            held_nibble = v;
            nibble_held = 1'b1;
         end
      endfunction

      function void put_run(int unsigned len);
         if (len >= 1 && len < ShortRunLimit) begin
            put_nibble(bupr_pkg::NibW'(len));
         end else begin
            put_nibble(bupr_pkg::EscNibble);
            put_nibble(bupr_pkg::NibW'(len));
            put_nibble(bupr_pkg::NibW'(len >> bupr_pkg::NibW));
         end
      endfunction

      function void note_pixel(logic ink, logic last_pixel);
         int unsigned w;
         int unsigned col;
         logic        coded;
         w = line_width;
         if (w < 1) w = 1;
         if (w > LineMax) w = LineMax;
         col = (column >= LineMax) ? LineMax - 1 : column;

         // Below the first row the coded value is the change from the pixel above.
         coded = ink;
         if (!first_row) coded = coded ^ line_store[col];
         line_store[col] = ink;

         if (col + 1 >= w) begin
            column    = 0;
            first_row = 1'b0;
         end else begin
            column = col + 1;
         end

         // A change of value closes the open run; a run that would pass the longest
         // chunk is cut there and followed by an empty run of the other value.
         if (coded != run_ink) begin
            put_run(run_len);
            run_ink = coded;
            run_len = 1;
         end else if (run_len >= bupr_pkg::MaxRunChunk) begin
            put_run(bupr_pkg::MaxRunChunk);
            put_run(0);
            run_len = 1;
         end else begin
            run_len++;
         end

         if (last_pixel) begin
            put_run(run_len);
            if (nibble_held) put_nibble(PadNibble);
            if (pixel_words.size() > 0) pixel_words[pixel_words.size() - 1].last_byte = 1'b1;
            start_image();
         end

         pixels_noted++;
         foreach (pixel_words[i]) expected_words.push_back(pixel_words[i]);
         pixel_words.delete();
      endfunction

      function void check_word(logic [bupr_pkg::CodeW-1:0] code_byte, logic last_byte);
         code_word_type want;
         words_checked++;
         if (expected_words.size() == 0) begin
            $error("code word %02h with last_byte %0b arrived while none was expected",
                   code_byte, last_byte);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         if (code_byte !== want.code_byte) begin
            $error("code_byte: expected %02h, actual %02h", want.code_byte, code_byte);
            errors++;
         end
         if (last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, actual %0b", want.last_byte, last_byte);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_we;
   logic [bupr_pkg::CfgW-1:0] csr_wdata;

   bupr_req_if req_if ();
   bupr_rsp_if rsp_if ();

   bilevel_up_prediction_nibble_rle DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   rle_scoreboard board = new();

   // When a burst flag is set, that side moves every word without waiting.
   bit          req_burst;
   bit          rsp_burst;
   int unsigned cycle_count = 0;
   int unsigned image_count = 0;
   int unsigned width_writes = 0;
   bit          pixel_plan[$];
   int          wide_choices[5] = '{4096, 4095, 2730, 8191, 2047};

   always #5 clock = ~clock;

   // The watchdog ends a run that hangs, for instance on a word that never arrives.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Both channels are observed at the clock edge, before any driver updates land.
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         board.note_pixel(req_if.ink, req_if.last_pixel);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         board.check_word(rsp_if.code_byte, rsp_if.last_byte);
      end
   end

   // The receiver draws a stall before each word it takes, so that back-pressure falls
   // on every phase of the queue and the coder behind it.
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, MaxGap);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   // One pixel word, after a drawn gap. With no gap, valid simply stays high.
   task automatic send_pixel(input logic ink, input logic last_pixel);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.ink        <= ink;
      req_if.last_pixel <= last_pixel;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Hold the sender until every expected word has come out. A pixel that codes to
   // nothing may still be inside the block, so a few more cycles pass after that.
   task automatic wait_for_quiet();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_width(input int w);
      wait_for_quiet();
      csr_we    <= 1'b1;
      csr_wdata <= bupr_pkg::CfgW'(w);
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_width(bupr_pkg::CfgW'(w));
      width_writes++;
   endtask

   // Sends the planned image and marks its final pixel. A split index, when not negative,
   // changes the width in the middle of the image. Rows only ever read columns below the
   // narrow limit, and the directed part has written all of those, so no row ever reads
   // an entry that was never stored.
   task automatic send_image(input int split_at, input int split_width);
      foreach (pixel_plan[i]) begin
         if (i == split_at) write_width(split_width);
         send_pixel(pixel_plan[i], i == pixel_plan.size() - 1);
      end
      image_count++;
   endtask

   function automatic void push_run(input bit ink, input int count);
      repeat (count) pixel_plan.push_back(ink);
   endfunction

   // Rows that repeat the row above code to long black runs, which is how the run limit
   // is reached on images narrower than a run.
   function automatic void plan_image(input int w, input int count, input bit copy_rows);
      row_mode_type mode;
      bit           run_ink;
      bit           solid_ink;
      bit           ink;
      pixel_plan.delete();
      run_ink   = $urandom_range(0, 1);
      solid_ink = 1'b0;
      mode      = RowRuns;
      for (int i = 0; i < count; i++) begin
         if (i % w == 0) begin
            mode      = copy_rows ? RowCopy : row_mode_type'($urandom_range(0, 4));
            solid_ink = $urandom_range(0, 1);
         end
         if (i < w && (mode == RowCopy || mode == RowFlip)) mode = RowRuns;
         case (mode)
            RowRandom: ink = $urandom_range(0, 1);
            RowCopy:   ink = pixel_plan[i - w];
            RowFlip:   ink = pixel_plan[i - w] ^ ($urandom_range(0, 4) == 0);
            RowSolid:  ink = solid_ink;
            default: begin
               if ($urandom_range(0, 7) == 0) run_ink = !run_ink;
               ink = run_ink;
            end
         endcase
         pixel_plan.push_back(ink);
      end
   endfunction

   initial begin
      int random_start;
      int pick;
      int w;
      int count;
      int split_at;
      int split_width;

      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.ink        = 1'b0;
      req_if.last_pixel = 1'b0;
      req_burst         = 1'b0;
      rsp_burst         = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed images on narrow rows. The first starts with white ink, so it opens with
      // an empty black run; its later rows code against the rows above them.
      write_width(4);
      pixel_plan = '{1, 1, 0, 1,  1, 0, 0, 1,  0, 0, 0, 0};
      send_image(-1, 0);
      // Images of one pixel: a lone black run padded to a word, and a lone white pixel
      // that needs the empty black run ahead of it.
      pixel_plan = '{0};
      send_image(-1, 0);
      pixel_plan = '{1};
      send_image(-1, 0);
      // One pixel per row: every pixel after the first codes against the one before.
      write_width(1);
      pixel_plan = '{1, 1, 0, 0, 1};
      send_image(-1, 0);

      // A first row as wide as the widest narrow image writes every line store column that
      // later rows read. It opens white, so an empty black run leads, then a white run that
      // just fits one nibble. The rows below repeat it and code to one black run that
      // passes the longest chunk and has to be cut.
      write_width(MaxNarrow);
      pixel_plan.delete();
      push_run(1'b1, 15);
      push_run(1'b0, MaxNarrow - 15);
      for (int i = MaxNarrow; i < MaxNarrow + LongCopies; i++) begin
         pixel_plan.push_back(pixel_plan[i - MaxNarrow]);
      end
      req_burst = 1'b1;
      send_image(-1, 0);

      // Random images until enough random pixels have gone through. Most are small rows
      // with structured content; a few are very wide first rows, a few are runs of
      // repeated rows, and some change the width partway through.
      random_start = board.pixels_noted;
      while (board.pixels_noted - random_start < RandomPixels) begin
         req_burst = ($urandom_range(0, 3) == 0);
         rsp_burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            w = $urandom_range(1, 3);
            plan_image(w, $urandom_range(30, 60), 1'b1);
         end else if (pick < 3) begin
            w = wide_choices[$urandom_range(0, 4)];
            plan_image(w, $urandom_range(5, 30), 1'b0);
         end else begin
            w = $urandom_range(1, MaxNarrow);
            count = $urandom_range(1, 3 * w + 4);
            if (count > 48) count = 48;
            plan_image(w, count, 1'b0);
         end
         write_width(w);
         split_at    = -1;
         split_width = 0;
         if ($urandom_range(0, 5) == 0 && pixel_plan.size() > 2) begin
            split_at    = $urandom_range(1, pixel_plan.size() - 1);
            split_width = $urandom_range(1, MaxNarrow);
         end
         send_image(split_at, split_width);
      end

      req_burst = 1'b0;
      rsp_burst = 1'b0;
      wait_for_quiet();
      repeat (4 * SettleCycles) @(posedge clock);

      $display("Encoded %0d images, %0d pixels in all, under %0d line width settings.",
               image_count, board.pixels_noted, width_writes);
      $display("Compared %0d code words with the prediction; %0d mismatches found.",
               board.words_checked, board.errors);
      if (board.errors == 0 && board.expected_words.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
